// ===== rtl/svge_pkg.sv =====
// Package: operation codes and shared types for the state vector gate engine.
`timescale 1ns / 1ps
package svge_pkg;
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_GATE  = 3'd2,
    OP_CNOT  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_READ,
    ST_RESP
  } state_t;
endpackage

// ===== rtl/state_vector_gate_engine_core.sv =====
// Top level: state vector store with gate, CNOT, read, write and clear sequencer.
`timescale 1ns / 1ps
// The amplitude vector sits in one memory of 2^MAX_QUBITS entries of 2*AMP_WIDTH bits,
// real part low. A gate or CNOT is a pass over the pairs that differ in the target
// bit: one pair is read per cycle through the two read ports, goes through a two-stage
// datapath (rounded products registered, then sums saturated) and is written back
// through the two write ports after the product register (a CNOT writes only pairs
// whose control bit is set); the pipeline then drains. Pairs never overlap, so no
// forwarding is needed. Clear writes all 2^MAX_QUBITS entries, one entry a cycle. One
// request is worked on at a time; the result sits in an output register and the next
// request is taken once it is gone. Entries never written since reset read as unknown
// data.
module state_vector_gate_engine_core
  import svge_pkg::*;
#(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 18
) (
  input  logic clk,
  input  logic rst,
  input  logic qubits_in_use_we,
  input  logic [3:0] qubits_in_use_wdata,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata, low bit up: operation, target_qubit, control_qubit, amplitude_index,
  // c0_re, c0_im, c1_re, c1_im, c2_re, c2_im, c3_re, c3_im, zero fill
  input  logic [((21 + 8*AMP_WIDTH + 7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata, low bit up: amp_re, amp_im, status, zero fill
  output logic [((2*AMP_WIDTH + 1 + 7)/8)*8-1:0] m_tdata
);
  localparam int AW    = MAX_QUBITS;
  localparam int DEPTH = 1 << MAX_QUBITS;
  localparam int FRAC  = AMP_WIDTH - 2;
  localparam int PW    = 2*AMP_WIDTH;
  localparam int SW    = 2*AMP_WIDTH + 2;
  localparam int IDXW  = 10;
  localparam int OUTW  = ((2*AMP_WIDTH + 1 + 7)/8)*8;

  // config register and clamp
  logic [3:0] qubits_in_use;
  always_ff @(posedge clk) begin
    if (rst) qubits_in_use <= 4'd10;
    else if (qubits_in_use_we)
      qubits_in_use <= qubits_in_use_wdata;
  end
  logic [4:0] n_act;
  always_comb begin
    if (qubits_in_use == 4'd0) n_act = 5'd1;
    else if (32'(qubits_in_use) > MAX_QUBITS) n_act = 5'(MAX_QUBITS);
    else n_act = {1'b0, qubits_in_use};
  end

  // request fields
  logic [2:0] f_op;
  logic [3:0] f_tq, f_cq;
  logic [IDXW-1:0] f_idx;
  assign f_op  = s_tdata[2:0];
  assign f_tq  = s_tdata[6:3];
  assign f_cq  = s_tdata[10:7];
  assign f_idx = s_tdata[20:11];

  // held request
  logic [2:0] op;
  logic [3:0] tq, cq;
  logic [AMP_WIDTH-1:0] cre [4];
  logic [AMP_WIDTH-1:0] cim [4];
  logic [AW:0] cnt;
  logic [AW:0] last;
  state_t state, state_next;
  logic status;
  logic [AMP_WIDTH-1:0] rd_re, rd_im;

  // memory
  logic [PW-1:0] mem [DEPTH];
  logic [AW-1:0] ra0, ra1, wa0, wa1;
  logic [PW-1:0] rq0, rq1, wd0, wd1;
  logic re_en, we0, we1;
  always_ff @(posedge clk) begin
    if (re_en) begin
      rq0 <= mem[ra0];
      rq1 <= mem[ra1];
    end
    if (we0) mem[wa0] <= wd0;
    if (we1) mem[wa1] <= wd1;
  end

  // pair index: insert 0 at target bit position of cnt
  logic [AW-1:0] base, tbit, cbit, lowmask;
  always_comb begin
    tbit    = AW'(1) << tq;
    cbit    = AW'(1) << cq;
    lowmask = tbit - AW'(1);
    base    = ((cnt[AW-1:0] & ~lowmask) << 1) | (cnt[AW-1:0] & lowmask);
  end

  // pipeline control: v1 = read data out, v2 = products registered
  logic v1, v2;
  logic [AW-1:0] a1_0, a1_1, a2_0, a2_1;
  logic is_gate;
  assign is_gate = (op == OP_GATE);

  logic issue;
  assign issue = (state == ST_RUN) && (op != OP_CLEAR);
  assign ra0 = (state == ST_RUN) ? base : AW'(f_idx);
  assign ra1 = base | tbit;
  assign re_en = issue || (state_next == ST_READ && state == ST_IDLE);
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else begin
      v1 <= issue && ((op == OP_GATE) || ((base & cbit) != '0));
      v2 <= v1;
    end
    a1_0 <= base; a1_1 <= base | tbit;
    a2_0 <= a1_0; a2_1 <= a1_1;
  end

  // stage 2: rounded products
  logic signed [AMP_WIDTH-1:0] ar, ai, br, bi;
  assign ar = rq0[AMP_WIDTH-1:0];
  assign ai = rq0[PW-1:AMP_WIDTH];
  assign br = rq1[AMP_WIDTH-1:0];
  assign bi = rq1[PW-1:AMP_WIDTH];

  // full-scale negative squared needs two bits above the amplitude width
  function automatic logic signed [AMP_WIDTH+1:0] rmul(logic signed [AMP_WIDTH-1:0] x,
                                                       logic signed [AMP_WIDTH-1:0] y);
    logic signed [2*AMP_WIDTH:0] xe, ye, p;
    xe = x;
    ye = y;
    p = xe * ye + (2*AMP_WIDTH+1)'(1 <<< (FRAC-1));
    return p[FRAC +: AMP_WIDTH+2];
  endfunction

  // 16 products: out k (0..3: r0,i0,r1,i1), term j
  logic signed [AMP_WIDTH+1:0] pr [4][4];
  logic [PW-1:0] pass0, pass1;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      pr[2*k][0] <= rmul($signed(cre[2*k]), ar);
      pr[2*k][1] <= -rmul($signed(cim[2*k]), ai);
      pr[2*k][2] <= rmul($signed(cre[2*k+1]), br);
      pr[2*k][3] <= -rmul($signed(cim[2*k+1]), bi);
      pr[2*k+1][0] <= rmul($signed(cre[2*k]), ai);
      pr[2*k+1][1] <= rmul($signed(cim[2*k]), ar);
      pr[2*k+1][2] <= rmul($signed(cre[2*k+1]), bi);
      pr[2*k+1][3] <= rmul($signed(cim[2*k+1]), br);
    end
    pass0 <= rq1;
    pass1 <= rq0;
  end

  function automatic logic [AMP_WIDTH-1:0] sat(logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((1 <<< (AMP_WIDTH-1)) - 1);
    lo = -SW'(1 <<< (AMP_WIDTH-1));
    if (v > hi) return hi[AMP_WIDTH-1:0];
    if (v < lo) return lo[AMP_WIDTH-1:0];
    return v[AMP_WIDTH-1:0];
  endfunction

  logic [AMP_WIDTH-1:0] res [4];
  always_comb begin
    for (int k = 0; k < 4; k++)
      res[k] = sat(SW'(pr[k][0]) + SW'(pr[k][1]) + SW'(pr[k][2]) + SW'(pr[k][3]));
  end

  // write ports
  always_comb begin
    we0 = 1'b0; we1 = 1'b0;
    wa0 = a2_0; wa1 = a2_1;
    wd0 = is_gate ? {res[1], res[0]} : pass0;
    wd1 = is_gate ? {res[3], res[2]} : pass1;
    if (v2) begin
      we0 = 1'b1; we1 = 1'b1;
    end else if (state == ST_RUN && op == OP_CLEAR) begin
      we0 = 1'b1;
      wa0 = cnt[AW-1:0];
      wd0 = (cnt == '0) ? PW'(1 << FRAC) : '0;
    end else if (state == ST_IDLE && s_tvalid && s_tready && f_op == OP_WRITE &&
                 32'(f_idx) < (1 << n_act)) begin
      we0 = 1'b1;
      wa0 = AW'(f_idx);
      wd0 = {s_tdata[21+AMP_WIDTH +: AMP_WIDTH], s_tdata[21 +: AMP_WIDTH]};
    end
  end

  // request check
  logic acc, bad;
  assign acc = s_tvalid && s_tready;
  always_comb begin
    case (f_op)
      OP_WRITE, OP_READ: bad = !(32'(f_idx) < (1 << n_act));
      OP_GATE:  bad = !({1'b0, f_tq} < n_act);
      OP_CNOT:  bad = !({1'b0, f_tq} < n_act) || !({1'b0, f_cq} < n_act) ||
                      (f_tq == f_cq);
      OP_CLEAR: bad = 1'b0;
      default:  bad = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (acc) begin
        if (bad || f_op == OP_WRITE) state_next = ST_RESP;
        else if (f_op == OP_READ) state_next = ST_READ;
        else state_next = ST_RUN;
      end
      ST_RUN:   if (cnt == last) state_next = (op == OP_CLEAR) ? ST_RESP : ST_DRAIN;
      ST_DRAIN: if (!v1 && !v2) state_next = ST_RESP;
      ST_READ:  state_next = ST_RESP;
      ST_RESP:  if (m_tready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && acc) begin
      op  <= f_op;
      tq  <= f_tq;
      cq  <= f_cq;
      status <= bad;
      for (int k = 0; k < 4; k++) begin
        cre[k] <= s_tdata[21 + 2*k*AMP_WIDTH +: AMP_WIDTH];
        cim[k] <= s_tdata[21 + (2*k+1)*AMP_WIDTH +: AMP_WIDTH];
      end
      cnt <= '0;
      last <= (f_op == OP_CLEAR) ? (AW+1)'(DEPTH - 1)
                                 : (AW+1)'((1 << (n_act - 5'd1)) - 1);
      rd_re <= '0;
      rd_im <= '0;
    end else if (state == ST_RUN) begin
      cnt <= cnt + (AW+1)'(1);
    end else if (state == ST_READ) begin
      rd_re <= rq0[AMP_WIDTH-1:0];
      rd_im <= rq0[PW-1:AMP_WIDTH];
    end
  end

  // outputs
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_RESP);
  assign m_tdata  = OUTW'({status, rd_im, rd_re});
endmodule
